// ===== sv/circle_box_penetration_vector_assert.svh =====
// Assertion macros shared by the checker of the penetration vector block.
// Every property is clocked on i_clk and switched off while i_rst_n is low.
`ifndef CIRCLE_BOX_PENETRATION_VECTOR_ASSERT_SVH
`define CIRCLE_BOX_PENETRATION_VECTOR_ASSERT_SVH

// Same-cycle implication.
`define CBPV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CBPV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cbpv_pkg.sv =====
`timescale 1ns / 1ps
package cbpv_pkg;

    // Pair kinds.
    localparam logic [2:0] ACT_CC = 3'd0;
    localparam logic [2:0] ACT_CB = 3'd1;
    localparam logic [2:0] ACT_BC = 3'd2;
    localparam logic [2:0] ACT_BB = 3'd3;

    localparam int PRE_STAGES = 6;
    localparam int ROOT_BITS  = 32;
    localparam int QUO_BITS   = 32;
    localparam int META_LAST  = PRE_STAGES + ROOT_BITS + QUO_BITS - 1;

    localparam logic signed [39:0] SAT_HI = 40'sd2147483647;
    localparam logic signed [39:0] SAT_LO = -40'sd2147483648;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] first_a_x;
        logic signed [31:0] first_a_y;
        logic signed [31:0] first_b_x;
        logic signed [31:0] first_b_y;
        logic [30:0]        first_radius;
        logic signed [31:0] second_a_x;
        logic signed [31:0] second_a_y;
        logic signed [31:0] second_b_x;
        logic signed [31:0] second_b_y;
        logic [30:0]        second_radius;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] pen_x;
        logic signed [31:0] pen_y;
        logic               found;
    } t_out_beat;

    // First stage: clamping, box sums and the raw differences.
    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic               in_box;
        logic signed [34:0] dx2;
        logic signed [34:0] dy2;
        logic signed [34:0] a2;
        logic signed [34:0] b2;
        logic [30:0]        r;
        logic signed [32:0] cc_dx;
        logic signed [32:0] cc_dy;
        logic [31:0]        cc_sum;
        logic signed [32:0] bb_iw;
        logic signed [32:0] bb_ih;
        logic               bb_ltx;
        logic               bb_lty;
    } t_p1;

    // What travels alongside the normalisation datapath.
    typedef struct packed {
        logic               found;
        logic               use_norm;
        logic               flip;
        logic signed [32:0] v_x;
        logic signed [32:0] v_y;
        logic signed [39:0] dir_x;
        logic signed [39:0] dir_y;
    } t_meta;

endpackage

// ===== sv/circle_box_penetration_vector.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake                   Beat
// in       input      i_in_valid / o_in_stall     cbpv_pkg::t_in_beat
// out      output     o_out_valid / i_out_stall   cbpv_pkg::t_out_beat
//
// One beat enters per cycle unless the pipe is frozen by an output stall.
// The pipe holds the 32-stage square root and the two 32-stage dividers.
// Reset clears only the valid bits of the stages and of the output register.
// A stall on a valid output beat freezes the whole pipe; o_in_stall is raised only then.
module circle_box_penetration_vector (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  cbpv_pkg::t_in_beat   i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output cbpv_pkg::t_out_beat  o_out_data,
    input  logic                 i_out_stall
);
    import cbpv_pkg::*;

    logic              r_out_valid;
    t_out_beat         r_out;
    logic              w_en;

    // Stage 1.
    logic              r_p1_vld;
    t_p1               r_p1;
    t_p1               n_p1;
    logic signed [31:0] w_cx, w_cy, w_mnx, w_mny, w_mxx, w_mxy, w_tx, w_ty;
    logic signed [31:0] w_ixn, w_iyn, w_ixx, w_iyx;
    logic [30:0]       w_r;

    // Meta pipe and valid bits.
    t_meta             r_meta [0:META_LAST];
    logic              r_vld  [0:META_LAST];
    t_meta             n_meta;
    logic [31:0]       n_s;
    logic [31:0]       r_s    [0:3];

    // Stage 2 working signals.
    logic signed [32:0] w_vx, w_vy;
    logic               w_inside, w_zx, w_zy, w_pick_x;
    logic signed [35:0] w_a2e, w_b2e, w_ma, w_mb, w_inx, w_iny;
    logic signed [39:0] w_dx, w_dy;

    // Normalisation datapath.
    logic [32:0]       r_mx, r_my, r_mm, r_mx2, r_my2;
    logic [5:0]        w_msb;
    logic [1:0]        r_rsh;
    logic [4:0]        r_lsh;
    logic [30:0]       r_sx, r_sy;
    logic [61:0]       r_sqx, r_sqy;
    logic [62:0]       r_px6, r_py6;
    logic [62:0]       r_sqn [0:ROOT_BITS];
    logic [62:0]       r_sqr [0:ROOT_BITS];
    logic [62:0]       r_prx [0:ROOT_BITS];
    logic [62:0]       r_pry [0:ROOT_BITS];

    logic [31:0]       w_len;
    logic [31:0]       r_drx [1:QUO_BITS];
    logic [31:0]       r_dry [1:QUO_BITS];
    logic [31:0]       r_dlx [1:QUO_BITS];
    logic [31:0]       r_dly [1:QUO_BITS];
    logic [31:0]       r_dqx [1:QUO_BITS];
    logic [31:0]       r_dqy [1:QUO_BITS];
    logic [31:0]       r_dln [1:QUO_BITS];

    // Output stage.
    logic signed [34:0] w_nx, w_ny, w_ex, w_ey;
    logic signed [39:0] w_fx, w_fy;
    t_out_beat          n_out;

    assign w_en        = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- Stage 1 ----------------
    always_comb begin
        if (i_in_data.action == ACT_BC) begin
            w_cx  = i_in_data.second_a_x;
            w_cy  = i_in_data.second_a_y;
            w_r   = i_in_data.second_radius;
            w_mnx = i_in_data.first_a_x;
            w_mny = i_in_data.first_a_y;
            w_mxx = i_in_data.first_b_x;
            w_mxy = i_in_data.first_b_y;
        end else begin
            w_cx  = i_in_data.first_a_x;
            w_cy  = i_in_data.first_a_y;
            w_r   = i_in_data.first_radius;
            w_mnx = i_in_data.second_a_x;
            w_mny = i_in_data.second_a_y;
            w_mxx = i_in_data.second_b_x;
            w_mxy = i_in_data.second_b_y;
        end
        // The upper bound is applied first, so the lower bound wins on an inverted box.
        w_tx = (w_cx > w_mxx) ? w_mxx : w_cx;
        w_ty = (w_cy > w_mxy) ? w_mxy : w_cy;
        w_ixn = (i_in_data.first_a_x > i_in_data.second_a_x) ?
                i_in_data.first_a_x : i_in_data.second_a_x;
        w_iyn = (i_in_data.first_a_y > i_in_data.second_a_y) ?
                i_in_data.first_a_y : i_in_data.second_a_y;
        w_ixx = (i_in_data.first_b_x < i_in_data.second_b_x) ?
                i_in_data.first_b_x : i_in_data.second_b_x;
        w_iyx = (i_in_data.first_b_y < i_in_data.second_b_y) ?
                i_in_data.first_b_y : i_in_data.second_b_y;

        n_p1.action = i_in_data.action;
        n_p1.px     = (w_tx < w_mnx) ? w_mnx : w_tx;
        n_p1.py     = (w_ty < w_mny) ? w_mny : w_ty;
        n_p1.cx     = w_cx;
        n_p1.cy     = w_cy;
        n_p1.in_box = (w_cx >= w_mnx) && (w_cx <= w_mxx) && (w_cy >= w_mny) && (w_cy <= w_mxy);
        n_p1.dx2    = (35'(w_cx) <<< 1) - (35'(w_mnx) + 35'(w_mxx));
        n_p1.dy2    = (35'(w_cy) <<< 1) - (35'(w_mny) + 35'(w_mxy));
        n_p1.a2     = ($signed({4'b0, w_r}) <<< 1) + (35'(w_mxx) - 35'(w_mnx));
        n_p1.b2     = ($signed({4'b0, w_r}) <<< 1) + (35'(w_mxy) - 35'(w_mny));
        n_p1.r      = w_r;
        n_p1.cc_dx  = 33'(i_in_data.first_a_x) - 33'(i_in_data.second_a_x);
        n_p1.cc_dy  = 33'(i_in_data.first_a_y) - 33'(i_in_data.second_a_y);
        n_p1.cc_sum = {1'b0, i_in_data.first_radius} + {1'b0, i_in_data.second_radius};
        n_p1.bb_iw  = 33'(w_ixx) - 33'(w_ixn);
        n_p1.bb_ih  = 33'(w_iyx) - 33'(w_iyn);
        n_p1.bb_ltx = (33'(i_in_data.first_a_x) + 33'(i_in_data.first_b_x)) <
                      (33'(i_in_data.second_a_x) + 33'(i_in_data.second_b_x));
        n_p1.bb_lty = (33'(i_in_data.first_a_y) + 33'(i_in_data.first_b_y)) <
                      (33'(i_in_data.second_a_y) + 33'(i_in_data.second_b_y));
    end

    // ---------------- Stage 2: pick the case ----------------
    always_comb begin
        w_vx     = 33'(r_p1.px) - 33'(r_p1.cx);
        w_vy     = 33'(r_p1.py) - 33'(r_p1.cy);
        w_inside = r_p1.in_box || (w_vx == '0 && w_vy == '0);
        w_zx     = (r_p1.dx2 == '0);
        w_zy     = (r_p1.dy2 == '0);
        w_a2e    = 36'(r_p1.a2);
        w_b2e    = 36'(r_p1.b2);
        w_ma     = w_a2e[35] ? -w_a2e : w_a2e;
        w_mb     = w_b2e[35] ? -w_b2e : w_b2e;
        // A zero offset on one axis forces the push onto the other axis.
        if (w_zx) begin
            w_pick_x = 1'b0;
        end else if (w_zy) begin
            w_pick_x = 1'b1;
        end else begin
            w_pick_x = (w_ma < w_mb);
        end
        w_inx = (36'(r_p1.dx2) - (r_p1.dx2[34] ? -w_a2e : w_a2e)) >>> 1;
        w_iny = (36'(r_p1.dy2) - (r_p1.dy2[34] ? -w_b2e : w_b2e)) >>> 1;
        if (w_zx && w_zy) begin
            w_dx = '0;
            w_dy = 40'(w_b2e >>> 1);
        end else if (w_pick_x) begin
            w_dx = 40'(w_inx);
            w_dy = '0;
        end else begin
            w_dx = '0;
            w_dy = 40'(w_iny);
        end

        n_meta.found    = 1'b1;
        n_meta.use_norm = 1'b0;
        n_meta.flip     = 1'b0;
        n_meta.v_x      = w_vx;
        n_meta.v_y      = w_vy;
        n_meta.dir_x    = '0;
        n_meta.dir_y    = '0;
        n_s             = {1'b0, r_p1.r};
        case (r_p1.action)
            ACT_CC: begin
                n_meta.v_x = r_p1.cc_dx;
                n_meta.v_y = r_p1.cc_dy;
                n_s        = r_p1.cc_sum;
                if (r_p1.cc_dx == '0 && r_p1.cc_dy == '0) begin
                    n_meta.dir_y = 40'(r_p1.cc_sum);
                end else begin
                    n_meta.use_norm = 1'b1;
                end
            end
            ACT_CB, ACT_BC: begin
                if (w_inside) begin
                    n_meta.dir_x = (r_p1.action == ACT_BC) ? -w_dx : w_dx;
                    n_meta.dir_y = (r_p1.action == ACT_BC) ? -w_dy : w_dy;
                end else begin
                    n_meta.use_norm = 1'b1;
                    n_meta.flip     = (r_p1.action == ACT_CB);
                end
            end
            ACT_BB: begin
                if (r_p1.bb_iw < r_p1.bb_ih) begin
                    n_meta.dir_x = r_p1.bb_ltx ? 40'(r_p1.bb_iw) : -40'(r_p1.bb_iw);
                end else begin
                    n_meta.dir_y = r_p1.bb_lty ? 40'(r_p1.bb_ih) : -40'(r_p1.bb_ih);
                end
            end
            default: begin
                n_meta.found = 1'b0;
            end
        endcase
    end

    // Position of the leading one of the larger magnitude.
    always_comb begin
        w_msb = '0;
        for (int i = 0; i < 33; i++) begin
            if (r_mm[i]) begin
                w_msb = 6'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            for (int i = 0; i <= META_LAST; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_p1_vld <= i_in_valid;
            r_vld[0] <= r_p1_vld;
            for (int i = 1; i <= META_LAST; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1      <= n_p1;
            r_meta[0] <= n_meta;
            r_s[0]    <= n_s;
            for (int i = 1; i <= META_LAST; i++) begin
                r_meta[i] <= r_meta[i-1];
            end
            for (int i = 1; i < 4; i++) begin
                r_s[i] <= r_s[i-1];
            end
            // Magnitudes.
            r_mx <= r_meta[0].v_x[32] ? 33'(-r_meta[0].v_x) : 33'(r_meta[0].v_x);
            r_my <= r_meta[0].v_y[32] ? 33'(-r_meta[0].v_y) : 33'(r_meta[0].v_y);
            r_mm <= ((r_meta[0].v_x[32] ? 33'(-r_meta[0].v_x) : 33'(r_meta[0].v_x)) >
                     (r_meta[0].v_y[32] ? 33'(-r_meta[0].v_y) : 33'(r_meta[0].v_y))) ?
                    (r_meta[0].v_x[32] ? 33'(-r_meta[0].v_x) : 33'(r_meta[0].v_x)) :
                    (r_meta[0].v_y[32] ? 33'(-r_meta[0].v_y) : 33'(r_meta[0].v_y));
            // Shift amounts that bring the larger magnitude into [2^30, 2^31).
            r_mx2 <= r_mx;
            r_my2 <= r_my;
            r_rsh <= (w_msb > 6'd30) ? 2'(w_msb - 6'd30) : 2'd0;
            r_lsh <= (w_msb < 6'd30) ? 5'(6'd30 - w_msb) : 5'd0;
            // Scaled components.
            r_sx <= (r_rsh != '0) ? 31'(r_mx2 >> r_rsh) : 31'(r_mx2 << r_lsh);
            r_sy <= (r_rsh != '0) ? 31'(r_my2 >> r_rsh) : 31'(r_my2 << r_lsh);
            // Squares and scaled numerators.
            r_sqx <= r_sx * r_sx;
            r_sqy <= r_sy * r_sy;
            r_px6 <= r_sx * r_s[3];
            r_py6 <= r_sy * r_s[3];
            r_sqn[0] <= {1'b0, r_sqx} + {1'b0, r_sqy};
            r_sqr[0] <= '0;
            r_prx[0] <= r_px6;
            r_pry[0] <= r_py6;
        end
    end

    // ---------------- Square root, one result bit per stage ----------------
    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
        localparam logic [62:0] L_BIT = 63'(1) << (2 * (ROOT_BITS - 1 - k));
        logic [62:0] w_t;
        assign w_t = r_sqr[k] + L_BIT;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (r_sqn[k] >= w_t) begin
                    r_sqn[k+1] <= r_sqn[k] - w_t;
                    r_sqr[k+1] <= (r_sqr[k] >> 1) + L_BIT;
                end else begin
                    r_sqn[k+1] <= r_sqn[k];
                    r_sqr[k+1] <= r_sqr[k] >> 1;
                end
                r_prx[k+1] <= r_prx[k];
                r_pry[k+1] <= r_pry[k];
            end
        end
    end

    assign w_len = (r_sqr[ROOT_BITS][31:0] == '0) ? 32'd1 : r_sqr[ROOT_BITS][31:0];

    // ---------------- Dividers, one quotient bit per stage ----------------
    for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
        localparam int L_B = QUO_BITS - 1 - j;
        logic [31:0] w_rx, w_ry, w_lx, w_ly, w_qx, w_qy, w_d;
        logic [32:0] w_tx2, w_ty2;
        if (j == 0) begin : g_first
            assign w_rx = {1'b0, r_prx[ROOT_BITS][62:32]};
            assign w_ry = {1'b0, r_pry[ROOT_BITS][62:32]};
            assign w_lx = r_prx[ROOT_BITS][31:0];
            assign w_ly = r_pry[ROOT_BITS][31:0];
            assign w_qx = '0;
            assign w_qy = '0;
            assign w_d  = w_len;
        end else begin : g_rest
            assign w_rx = r_drx[j];
            assign w_ry = r_dry[j];
            assign w_lx = r_dlx[j];
            assign w_ly = r_dly[j];
            assign w_qx = r_dqx[j];
            assign w_qy = r_dqy[j];
            assign w_d  = r_dln[j];
        end
        assign w_tx2 = {w_rx, w_lx[L_B]};
        assign w_ty2 = {w_ry, w_ly[L_B]};
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dlx[j+1] <= w_lx;
                r_dly[j+1] <= w_ly;
                r_dln[j+1] <= w_d;
                if (w_tx2 >= {1'b0, w_d}) begin
                    r_drx[j+1] <= 32'(w_tx2 - {1'b0, w_d});
                    r_dqx[j+1] <= w_qx | (32'(1) << L_B);
                end else begin
                    r_drx[j+1] <= 32'(w_tx2);
                    r_dqx[j+1] <= w_qx;
                end
                if (w_ty2 >= {1'b0, w_d}) begin
                    r_dry[j+1] <= 32'(w_ty2 - {1'b0, w_d});
                    r_dqy[j+1] <= w_qy | (32'(1) << L_B);
                end else begin
                    r_dry[j+1] <= 32'(w_ty2);
                    r_dqy[j+1] <= w_qy;
                end
            end
        end
    end

    // ---------------- Output stage ----------------
    always_comb begin
        w_nx = $signed({3'b0, r_dqx[QUO_BITS]});
        w_ny = $signed({3'b0, r_dqy[QUO_BITS]});
        if (r_meta[META_LAST].v_x[32]) begin
            w_nx = -w_nx;
        end
        if (r_meta[META_LAST].v_y[32]) begin
            w_ny = -w_ny;
        end
        w_ex = 35'(r_meta[META_LAST].v_x) - w_nx;
        w_ey = 35'(r_meta[META_LAST].v_y) - w_ny;
        if (r_meta[META_LAST].flip) begin
            w_ex = -w_ex;
            w_ey = -w_ey;
        end
        w_fx = r_meta[META_LAST].use_norm ? 40'(w_ex) : r_meta[META_LAST].dir_x;
        w_fy = r_meta[META_LAST].use_norm ? 40'(w_ey) : r_meta[META_LAST].dir_y;
        if (w_fx > SAT_HI) begin
            n_out.pen_x = SAT_HI[31:0];
        end else if (w_fx < SAT_LO) begin
            n_out.pen_x = SAT_LO[31:0];
        end else begin
            n_out.pen_x = w_fx[31:0];
        end
        if (w_fy > SAT_HI) begin
            n_out.pen_y = SAT_HI[31:0];
        end else if (w_fy < SAT_LO) begin
            n_out.pen_y = SAT_LO[31:0];
        end else begin
            n_out.pen_y = w_fy[31:0];
        end
        n_out.found = r_meta[META_LAST].found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_vld[META_LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== sv/cbpv_checker.sv =====
`timescale 1ns / 1ps
module cbpv_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input cbpv_pkg::t_out_beat o_out_data,
    input logic                i_out_stall
);
    `include "circle_box_penetration_vector_assert.svh"

    // A stalled beat stays offered and unchanged.
    `CBPV_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result beat dropped under stall")
    `CBPV_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_data), "result beat changed under stall")

    // The input side is held back only by a waiting, stalled result.
    `CBPV_ASSERT_NOW(a_in_stall_cause, o_in_stall, o_out_valid && i_out_stall, "input stalled without cause")

    // An unsupported pair carries a zero vector.
    `CBPV_ASSERT_NOW(a_zero_unfound, o_out_valid && !o_out_data.found, o_out_data.pen_x == 32'sd0 && o_out_data.pen_y == 32'sd0, "unsupported pair gave a nonzero vector")

endmodule

bind circle_box_penetration_vector cbpv_checker u_cbpv_checker (.*);
